// ===== rtl/core/sefr_pkg.sv =====
// Shared types and codes for the STX/ETX frame receiver.
// No dependencies; used by sefr_seq and stx_etx_frame_receiver.
`default_nettype none

package sefr_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 6;

    typedef logic [1:0]        kind_t;
    typedef logic [DATA_W-1:0] byte_t;

    localparam byte_t CODE_STX = 8'h02;
    localparam byte_t CODE_ETX = 8'h03;
    localparam byte_t CODE_ENQ = 8'h05;
    localparam byte_t CODE_ACK = 8'h06;

    localparam kind_t KIND_ACK      = 2'd0;
    localparam kind_t KIND_BYTE     = 2'd1;
    localparam kind_t KIND_EMPTY    = 2'd2;
    localparam kind_t KIND_OVERFLOW = 2'd3;

    // Command from the decoder to the readout sequencer.
    typedef struct packed {
        logic  readout;   // 1: stream the stored frame, 0: one single result
        kind_t kind;
        byte_t data;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sefr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sefr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sefr_seq.sv =====
// Result sequencer: output register, held single result and frame readout.
// Depends on sefr_pkg; drives the read port of the frame store RAM.
`default_nettype none

module sefr_seq #(
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cmd_valid,
    input  wire sefr_pkg::cmd_t                      cmd,
    input  wire logic [$clog2(FRAME_DEPTH+1)-1:0]    cmd_len,
    output logic                                     busy,
    output logic                                     rd_en,
    output logic      [$clog2(FRAME_DEPTH)-1:0]      rd_addr,
    input  wire logic [sefr_pkg::DATA_W-1:0]         rd_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output sefr_pkg::kind_t                          kind,
    output logic      [sefr_pkg::DATA_W-1:0]         data_byte,
    output logic      [sefr_pkg::LEN_W-1:0]          frame_length,
    output logic                                     last
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                len_reg, len_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         rd_last_reg, rd_last_next;
    sefr_pkg::kind_t              pend_kind_reg, pend_kind_next;
    sefr_pkg::byte_t              pend_data_reg, pend_data_next;
    logic                         out_valid_reg, out_valid_next;
    sefr_pkg::kind_t              out_kind_reg, out_kind_next;
    sefr_pkg::byte_t              out_data_reg, out_data_next;
    logic [sefr_pkg::LEN_W-1:0]   out_len_reg, out_len_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        rd_pend_next   = rd_pend_reg;
        rd_last_next   = rd_last_reg;
        pend_kind_next = pend_kind_reg;
        pend_data_next = pend_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.readout)
                    begin
                        state_next = ST_READ;
                        idx_next   = '0;
                        len_next   = cmd_len;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = cmd.kind;
                        out_data_next  = cmd.data;
                        out_len_next   = '0;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        state_next     = ST_SINGLE;
                        pend_kind_next = cmd.kind;
                        pend_data_next = cmd.data;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_data_next  = pend_data_reg;
                    out_len_next   = '0;
                    out_last_next  = 1'b1;
                end
            end
            ST_READ:
            begin
                if (rd_pend_reg)
                begin
                    // output register is empty here: reads issue only when it frees
                    rd_pend_next   = 1'b0;
                    out_valid_next = 1'b1;
                    out_kind_next  = sefr_pkg::KIND_BYTE;
                    out_data_next  = rd_data;
                    out_len_next   = sefr_pkg::LEN_W'(len_reg);
                    out_last_next  = rd_last_reg;
                    if (idx_reg == len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg != len_reg && out_free)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_last_next = (idx_reg + CW'(1)) == len_reg;
                    idx_next     = idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        rd_last_reg   <= rd_last_next;
        pend_kind_reg <= pend_kind_next;
        pend_data_reg <= pend_data_next;
        out_kind_reg  <= out_kind_next;
        out_data_reg  <= out_data_next;
        out_len_reg   <= out_len_next;
        out_last_reg  <= out_last_next;
    end

    assign rd_addr      = idx_reg[AW-1:0];
    assign busy         = state_reg != ST_IDLE;
    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign data_byte    = out_data_reg;
    assign frame_length = out_len_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/stx_etx_frame_receiver.sv =====
// Top level of the STX/ETX frame receiver: byte decoder, fill count, frame store.
// Depends on sefr_pkg, sefr_ram and sefr_seq.
`default_nettype none

// Takes one received byte per item and gathers plain bytes into a frame store
// of FRAME_DEPTH entries. ENQ answers with an ACK result, STX restarts the frame,
// ETX delivers the stored frame byte by byte (or one empty-frame result), and a
// byte arriving on a full store is dropped with an overflow notice and resets the
// fill count. Plain bytes and STX never stall the input. An ETX with stored bytes
// holds in_ready low until its last byte is in the output register; the frame is
// read through the single registered read port, one read in flight at a time, and
// each read waits for the output register to free. A single result waiting on a
// stalled output is held aside, and the next item is taken once it has moved on.

module stx_etx_frame_receiver #(
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sefr_pkg::DATA_W-1:0] rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [1:0]                  kind,
    output logic      [sefr_pkg::DATA_W-1:0] data_byte,
    output logic      [sefr_pkg::LEN_W-1:0]  frame_length,
    output logic                             last
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);

    logic [CW-1:0]         fill_count_reg, fill_count_next;
    logic                  in_accept;
    logic                  full;
    logic                  seq_busy;
    logic                  cmd_valid;
    sefr_pkg::cmd_t        cmd;
    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    sefr_pkg::byte_t       rd_data;

    assign in_ready  = !seq_busy;
    assign in_accept = in_valid && in_ready;
    assign full      = fill_count_reg == CW'(FRAME_DEPTH);

    always_comb
    begin
        fill_count_next = fill_count_reg;
        cmd_valid       = 1'b0;
        cmd.readout     = 1'b0;
        cmd.kind        = sefr_pkg::KIND_ACK;
        cmd.data        = '0;
        wr_en           = 1'b0;
        if (in_accept)
        begin
            if (full)
            begin
                fill_count_next = '0;
                cmd_valid       = 1'b1;
                cmd.kind        = sefr_pkg::KIND_OVERFLOW;
            end
            else
            begin
                case (rx_byte)
                    sefr_pkg::CODE_ENQ:
                    begin
                        cmd_valid = 1'b1;
                        cmd.kind  = sefr_pkg::KIND_ACK;
                        cmd.data  = sefr_pkg::CODE_ACK;
                    end
                    sefr_pkg::CODE_STX:
                    begin
                        fill_count_next = '0;
                    end
                    sefr_pkg::CODE_ETX:
                    begin
                        cmd_valid = 1'b1;
                        if (fill_count_reg == '0)
                        begin
                            cmd.kind = sefr_pkg::KIND_EMPTY;
                        end
                        else
                        begin
                            cmd.readout = 1'b1;
                            cmd.kind    = sefr_pkg::KIND_BYTE;
                        end
                    end
                    default:
                    begin
                        wr_en           = 1'b1;
                        fill_count_next = fill_count_reg + CW'(1);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    sefr_ram #(
        .WIDTH (sefr_pkg::DATA_W),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_count_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sefr_seq #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_len      (fill_count_reg),
        .busy         (seq_busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .last         (last)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(FRAME_DEPTH))
        else $error("fill count beyond store depth");

    a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !seq_busy && !rd_en)
        else $error("store written during frame readout");

    a_full_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && full |=> fill_count_reg == '0 && seq_busy == 1'b0 || out_valid)
        else $error("full store not cleared on overflow");

    a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sefr_pkg::KIND_BYTE |-> frame_length != '0)
        else $error("frame byte with zero length");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for stx_etx_frame_receiver: random and directed byte streams.
// A scoreboard class predicts the results of every accepted byte and checks each output item.
// Depends on sefr_pkg and the receiver RTL.
`default_nettype none

module testbench;

    localparam int FRAME_DEPTH = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int LEN_W       = sefr_pkg::LEN_W;

    class frame_scoreboard;
        typedef struct {
            sefr_pkg::kind_t   kind;
            sefr_pkg::byte_t   data;
            logic [LEN_W-1:0]  len;
            logic              last;
        } result_t;

        logic [6:0]      held;
        sefr_pkg::byte_t frame [FRAME_DEPTH];
        result_t         due [$];
        int              errors;

        function new();
            held   = '0;
            errors = 0;
        endfunction

        function void add(sefr_pkg::kind_t k, sefr_pkg::byte_t d, logic [LEN_W-1:0] len,
                          logic lst);
            result_t r;
            r.kind = k;
            r.data = d;
            r.len  = len;
            r.last = lst;
            due.push_back(r);
        endfunction

        function void note_byte(sefr_pkg::byte_t b);
            if (held >= FRAME_DEPTH)
            begin
                held = '0;
                add(sefr_pkg::KIND_OVERFLOW, '0, '0, 1'b1);
                return;
            end
            case (b)
                sefr_pkg::CODE_ENQ: add(sefr_pkg::KIND_ACK, sefr_pkg::CODE_ACK, '0, 1'b1);
                sefr_pkg::CODE_STX: held = '0;
                sefr_pkg::CODE_ETX:
                begin
                    if (held == 0)
                        add(sefr_pkg::KIND_EMPTY, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < held; i++)
                            add(sefr_pkg::KIND_BYTE, frame[i], held[LEN_W-1:0],
                                (i + 1 == held));
                end
                default:
                begin
                    frame[held[5:0]] = b;
                    held = held + 7'd1;
                end
            endcase
        endfunction

        function void check_result(sefr_pkg::kind_t k, sefr_pkg::byte_t d,
                                   logic [LEN_W-1:0] len, logic lst);
            result_t e;
            if (due.size() == 0)
            begin
                $error("unexpected result: kind %0d, data_byte %0h", k, d);
                errors++;
                return;
            end
            e = due.pop_front();
            if (k !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, k);
                errors++;
            end
            if (d !== e.data)
            begin
                $error("data_byte: expected %0h, actual %0h", e.data, d);
                errors++;
            end
            if (len !== e.len)
            begin
                $error("frame_length: expected %0d, actual %0d", e.len, len);
                errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0d, actual %0d", e.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    sefr_pkg::byte_t  rx_byte   = '0;
    logic             out_ready = 1'b0;
    logic             in_ready;
    logic             out_valid;
    logic [1:0]       kind;
    sefr_pkg::byte_t  data_byte;
    logic [LEN_W-1:0] frame_length;
    logic             last;

    int tx_idle_pct = 9;
    int rx_idle_pct = 48;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int sent = 0;

    frame_scoreboard sb = new();

    stx_etx_frame_receiver #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .last         (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(kind, data_byte, frame_length, last);
    end

    function automatic sefr_pkg::byte_t plain_byte();
        sefr_pkg::byte_t b;
        do
            b = sefr_pkg::byte_t'($urandom_range(255));
        while (b == sefr_pkg::CODE_STX || b == sefr_pkg::CODE_ETX || b == sefr_pkg::CODE_ENQ);
        return b;
    endfunction

    task automatic send_byte(input sefr_pkg::byte_t b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_frame(input int n, input bit twice);
        send_byte(sefr_pkg::CODE_STX);
        repeat (n)
            send_byte(plain_byte());
        send_byte(sefr_pkg::CODE_ETX);
        if (twice)
            send_byte(sefr_pkg::CODE_ETX);
    endtask

    task automatic random_items(input int count);
        int start;
        int sel;
        start = sent;
        while (sent - start < count)
        begin
            sel = $urandom_range(99);
            if (sel < 55)
                send_frame($urandom_range(8), $urandom_range(99) < 20);
            else if (sel < 65)
                send_byte(sefr_pkg::CODE_ENQ);
            else if (sel < 80)
                send_byte(sefr_pkg::byte_t'($urandom_range(255)));
            else if (sel < 90)
            begin
                // frame abandoned by a fresh STX
                send_byte(sefr_pkg::CODE_STX);
                repeat ($urandom_range(1, 5))
                    send_byte(plain_byte());
            end
            else if (sel < 95)
                send_byte(plain_byte());
            else
                drain_results();
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(sefr_pkg::CODE_ETX);
        send_byte(sefr_pkg::CODE_ENQ);
        send_byte(sefr_pkg::CODE_STX);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h04);
        send_byte(8'h06);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(sefr_pkg::CODE_ETX);
        send_byte(sefr_pkg::CODE_ETX);
        send_byte(8'h10);
        send_byte(sefr_pkg::CODE_ENQ);
        send_byte(8'h20);
        send_byte(sefr_pkg::CODE_ETX);
        send_byte(sefr_pkg::CODE_STX);
        send_byte(sefr_pkg::CODE_ETX);
        send_frame(1, 1'b0);

        // longest frame, then a full store rejecting ETX
        send_frame(FRAME_DEPTH - 1, 1'b0);
        send_byte(plain_byte());
        send_byte(sefr_pkg::CODE_ETX);
        send_byte(sefr_pkg::CODE_ETX);
        drain_results();

        random_items(27);
        drain_results();

        tx_idle_pct = 48;
        rx_idle_pct = 9;
        random_items(27);
        drain_results();

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        random_items(26);
        drain_results();

        repeat (2 * FRAME_DEPTH + 8) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/sefr_pkg.sv
rtl/core/sefr_ram.sv
rtl/core/sefr_seq.sv
rtl/core/stx_etx_frame_receiver.sv
verif/testbench.sv
